// ===== sv/dmtt_pkg.sv =====
// Shared types and constants for the direct-mapped transposition table.
// No dependencies; imported by dmtt_front, dmtt_queue, dmtt_back and the top level.
`timescale 1ns / 1ps

package dmtt_pkg;

    // field widths of the stream items
    localparam int HASH_W     = 64;
    localparam int IN_SCORE_W = 16;
    localparam int BOUND_W    = 2;
    localparam int DEPTH_W    = 8;
    localparam int IN_MOVE_W  = 16;
    localparam int OP_W       = 2;

    // packed bus widths (rounded up to whole bytes)
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 48;

    // defaults for the top-level parameters
    localparam int INDEX_BITS_DEF  = 16;
    localparam int MOVE_WIDTH_DEF  = 16;
    localparam int SCORE_WIDTH_DEF = 16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP      = 2'd0,
        OP_SAVE_DERIVE = 2'd1,
        OP_SAVE_GIVEN  = 2'd2,
        OP_CLEAR       = 2'd3
    } op_t;

    typedef enum logic [BOUND_W-1:0] {
        BOUND_NONE  = 2'd0,
        BOUND_UPPER = 2'd1,
        BOUND_LOWER = 2'd2,
        BOUND_EXACT = 2'd3
    } bound_t;

    // classified command, as queued for the back end
    typedef struct packed {
        op_t                    op;
        logic [HASH_W-1:0]      hash;
        logic [IN_SCORE_W-1:0]  score;
        bound_t                 bound;
        logic [DEPTH_W-1:0]     depth;
        logic [IN_MOVE_W-1:0]   move;
    } cmd_t;

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== sv/dmtt_ram.sv =====
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dmtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dmtt_front.sv =====
// Front end: takes input transfers, decodes the op and derives the bound.
// Depends on dmtt_pkg; feeds dmtt_queue.
`timescale 1ns / 1ps

module dmtt_front import dmtt_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  back_status_t         status,
    input  logic                 q_full,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic signed [IN_SCORE_W-1:0] score;
    logic signed [IN_SCORE_W-1:0] alpha;
    logic signed [IN_SCORE_W-1:0] beta;
    bound_t                       bound_given;
    bound_t                       bound_derived;
    op_t                          op;

    assign op          = op_t'(s_tuser);
    assign score       = $signed(s_tdata[79:64]);
    assign alpha       = $signed(s_tdata[95:80]);
    assign beta        = $signed(s_tdata[111:96]);
    assign bound_given = bound_t'(s_tdata[113:112]);

    // upper wins over lower when the window is inverted
    always_comb begin
        if (score <= alpha) begin
            bound_derived = BOUND_UPPER;
        end else if (score >= beta) begin
            bound_derived = BOUND_LOWER;
        end else begin
            bound_derived = BOUND_EXACT;
        end
    end

    always_comb begin
        push_cmd.op    = op;
        push_cmd.hash  = s_tdata[63:0];
        push_cmd.score = s_tdata[79:64];
        push_cmd.depth = s_tdata[121:114];
        push_cmd.move  = s_tdata[137:122];
        case (op)
            OP_SAVE_DERIVE: push_cmd.bound = bound_derived;
            OP_SAVE_GIVEN:  push_cmd.bound = bound_given;
            default:        push_cmd.bound = BOUND_NONE;
        endcase
    end

    assign s_tready = !q_full && !status.clearing;
    assign push     = s_tvalid && s_tready;

endmodule

// ===== sv/dmtt_queue.sv =====
// Two-entry command queue decoupling front and back ends.
// Depends on dmtt_pkg.
`timescale 1ns / 1ps

module dmtt_queue import dmtt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/dmtt_back.sv =====
// Back end: runs queued commands against the table RAM, sweeps clears and
// holds the result register. Depends on dmtt_pkg and dmtt_ram.
`timescale 1ns / 1ps

module dmtt_back import dmtt_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF,
    parameter int MOVE_WIDTH  = MOVE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output back_status_t         status
);

    localparam int ENTRY_W = SCORE_WIDTH + BOUND_W + DEPTH_W + MOVE_WIDTH;
    localparam int WORD_W  = HASH_W + ENTRY_W;
    localparam int ENTRIES = 1 << INDEX_BITS;
    localparam logic signed [32:0] SMAX = (33'sd1 <<< (SCORE_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SMIN = -SMAX - 33'sd1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [INDEX_BITS-1:0]  clr_idx_reg, clr_idx_next;
    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   ram_en, ram_we;
    logic [INDEX_BITS-1:0]  ram_addr;
    logic [WORD_W-1:0]      ram_wdata, ram_rdata, save_word;

    // score saturation and move fitting on the way in
    logic signed [32:0]     score33, sat33;
    logic [31:0]            move32_in;

    // stored entry fields on the way out
    logic [HASH_W-1:0]      rd_tag;
    logic [SCORE_WIDTH-1:0] rd_score;
    logic [BOUND_W-1:0]     rd_bound;
    logic [DEPTH_W-1:0]     rd_depth;
    logic [MOVE_WIDTH-1:0]  rd_move;
    logic signed [31:0]     rd_score32;
    logic [31:0]            rd_move32;
    logic                   rd_hit;
    logic                   out_free;

    dmtt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign score33   = 33'($signed(q_cmd.score));
    assign sat33     = (score33 > SMAX) ? SMAX : ((score33 < SMIN) ? SMIN : score33);
    assign move32_in = 32'(q_cmd.move);
    assign save_word = {q_cmd.hash, sat33[SCORE_WIDTH-1:0], q_cmd.bound, q_cmd.depth,
                        move32_in[MOVE_WIDTH-1:0]};

    assign rd_tag     = ram_rdata[WORD_W-1 -: HASH_W];
    assign rd_score   = ram_rdata[ENTRY_W-1 -: SCORE_WIDTH];
    assign rd_bound   = ram_rdata[MOVE_WIDTH+DEPTH_W +: BOUND_W];
    assign rd_depth   = ram_rdata[MOVE_WIDTH +: DEPTH_W];
    assign rd_move    = ram_rdata[MOVE_WIDTH-1:0];
    assign rd_score32 = 32'($signed(rd_score));
    assign rd_move32  = 32'(rd_move);
    assign rd_hit     = (rd_tag == hash_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        hash_next     = hash_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        q_pop         = 1'b0;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = q_cmd.hash[INDEX_BITS-1:0];
        ram_wdata     = save_word;
        case (state_reg)
            ST_CLEAR: begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_LOOKUP: begin
                            ram_en     = 1'b1;
                            hash_next  = q_cmd.hash;
                            state_next = ST_READ;
                        end
                        OP_SAVE_DERIVE, OP_SAVE_GIVEN: begin
                            ram_en = 1'b1;
                            ram_we = 1'b1;
                        end
                        OP_CLEAR: begin
                            clr_idx_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = rd_hit;
                    m_tdata_next  = '0;
                    if (rd_hit) begin
                        m_tdata_next[15:0]  = rd_score32[15:0];
                        m_tdata_next[17:16] = rd_bound;
                        m_tdata_next[25:18] = rd_depth;
                        m_tdata_next[41:26] = rd_move32[15:0];
                    end
                    state_next = ST_RUN;
                end
            end
            default: begin
                clr_idx_next = '0;
                state_next   = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg    <= hash_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tuser         = m_tuser_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.clearing = (state_reg == ST_CLEAR);

endmodule

// ===== sv/direct_mapped_transposition_table.sv =====
// Top level of the direct-mapped transposition table: front end, command
// queue and back end. Depends on dmtt_pkg, dmtt_front, dmtt_queue, dmtt_back.
`timescale 1ns / 1ps

// Direct-mapped, always-replace transposition table with 2^INDEX_BITS entries.
// Input stream (s_): one transfer is one command; s_tuser holds the op (lookup,
// save with derived bound, save with given bound, clear all). Output stream
// (m_): one transfer per lookup only, m_tuser is the hit flag; a miss returns
// an all-zero payload. Saves and clears produce no transfer.
// Commands: a save is a single write on the table RAM port; a lookup reads the
// RAM, then compares the tag into the result register, and the back end takes
// no new command meanwhile. A clear sweeps all 2^INDEX_BITS entries (65536 by
// default) one entry per cycle; commands behind it wait in the queue.
// Path: a lookup passes the queue slot, the RAM read data register and the
// result register before m_tvalid rises.
// Reset: synchronous, active low. After reset the RAM is swept to zero and
// s_tready stays low throughout the sweep.
// Stalls: the result register holds while m_tready is low; the 2-entry queue
// keeps taking input meanwhile until it fills, then s_tready drops.

module direct_mapped_transposition_table import dmtt_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int MOVE_WIDTH  = MOVE_WIDTH_DEF,
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, from bit 0: hash[63:0], score[79:64], alpha[95:80],
    // beta[111:96], bound_in[113:112], search_depth[121:114],
    // move_code[137:122], zero pad [143:138]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,   // op[1:0]
    // m_tdata, from bit 0: found_score[15:0], found_bound[17:16],
    // found_depth[25:18], found_move[41:26], zero pad [47:42]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser    // hit
);

    back_status_t status;
    logic         q_full, push, pop, q_valid;
    cmd_t         push_cmd, q_cmd;

    // decode and bound derivation, gated by queue space and clear sweep
    dmtt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // lets the front keep taking transfers while a result is stalled
    dmtt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // table RAM, clear sweeper and result register
    dmtt_back #(
        .INDEX_BITS  (INDEX_BITS),
        .SCORE_WIDTH (SCORE_WIDTH),
        .MOVE_WIDTH  (MOVE_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (status)
    );

    // no input transfer while the RAM is being swept
    a_no_accept_in_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !(s_tvalid && s_tready)
    ) else $error("input transfer accepted during clear sweep");

    // a miss never leaks stale entry contents
    a_miss_is_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0)
    ) else $error("miss result carries non-zero payload");

    // leaving reset always starts the clear sweep
    a_sweep_after_reset: assert property (
        @(posedge aclk)
        ($past(!aresetn) && aresetn) |-> status.clearing
    ) else $error("no clear sweep after reset");

    // a queued command only leaves when the queue holds one
    a_pop_needs_entry: assert property (
        @(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid
    ) else $error("command popped from empty queue");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for direct_mapped_transposition_table.
// Depends on dmtt_pkg and the table RTL; it carries its own mirror of the table
// contents and checks every lookup transfer against it or a hand-set result.
`timescale 1ns / 1ps

module tb;
    import dmtt_pkg::*;

    localparam int INDEX_W        = INDEX_BITS_DEF;
    localparam int RAND_ITEMS     = 1730;
    localparam int POOL_SIZE      = 24;
    localparam int STALL_MAX      = 13;
    localparam int DRAIN_CYCLES   = 16;
    // a clear or the reset sweep holds off input transfers throughout the RAM sweep
    localparam int WATCHDOG_LIMIT = 4 * (1 << INDEX_W);

    typedef struct packed {
        logic                   hit;
        logic signed [15:0]     score;
        bound_t                 bnd;
        logic [DEPTH_W-1:0]     depth;
        logic [IN_MOVE_W-1:0]   mv;
    } probe_t;

    typedef struct {
        op_t                    op;
        logic [HASH_W-1:0]      hash;
        logic signed [15:0]     score;
        logic signed [15:0]     alpha;
        logic signed [15:0]     beta;
        bound_t                 bnd;
        logic [DEPTH_W-1:0]     depth;
        logic [IN_MOVE_W-1:0]   mv;
        bit                     typed;  // want is fixed by hand
        probe_t                 want;
    } tt_cmd_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // mirror of the table; an absent index reads as a cleared entry
    logic [HASH_W-1:0]    tag_mirror [int unsigned];
    probe_t               slot_mirror [int unsigned];
    probe_t               pending_probes [$];
    logic [HASH_W-1:0]    hash_pool [POOL_SIZE];
    tt_cmd_t              directed_rows [$];
    bit                   src_burst = 1'b0;
    int unsigned          mismatches = 0;
    int unsigned          quiet_cycles = 0;

    direct_mapped_transposition_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic tt_cmd_t cmd_row(input op_t op, input logic [HASH_W-1:0] hash,
                                        input int score, input int alpha, input int beta,
                                        input bound_t bnd, input int depth, input int mv);
        tt_cmd_t c;
        c.op    = op;
        c.hash  = hash;
        c.score = 16'(score);
        c.alpha = 16'(alpha);
        c.beta  = 16'(beta);
        c.bnd   = bnd;
        c.depth = 8'(depth);
        c.mv    = 16'(mv);
        c.typed = 1'b0;
        c.want  = '0;
        return c;
    endfunction

    function automatic tt_cmd_t probe_row(input logic [HASH_W-1:0] hash, input logic hit,
                                          input int score, input bound_t bnd,
                                          input int depth, input int mv);
        tt_cmd_t c;
        c = cmd_row(OP_LOOKUP, hash, 0, 0, 0, BOUND_NONE, 0, 0);
        c.typed      = 1'b1;
        c.want.hit   = hit;
        c.want.score = 16'(score);
        c.want.bnd   = bnd;
        c.want.depth = 8'(depth);
        c.want.mv    = 16'(mv);
        return c;
    endfunction

    // applies one command to the mirror; returns the lookup result (zero otherwise)
    function automatic probe_t tt_predict(input tt_cmd_t c);
        int unsigned       idx;
        logic [HASH_W-1:0] tag;
        probe_t            res;
        idx = 32'(c.hash[INDEX_W-1:0]);
        res = '0;
        case (c.op)
            OP_LOOKUP: begin
                tag = tag_mirror.exists(idx) ? tag_mirror[idx] : '0;
                if (tag == c.hash) begin
                    if (slot_mirror.exists(idx))
                        res = slot_mirror[idx];
                    res.hit = 1'b1;
                end
            end
            OP_SAVE_DERIVE, OP_SAVE_GIVEN: begin
                res.score = c.score;
                res.depth = c.depth;
                res.mv    = c.mv;
                if (c.op == OP_SAVE_GIVEN)
                    res.bnd = c.bnd;
                else if (c.score <= c.alpha)
                    res.bnd = BOUND_UPPER;
                else if (c.score >= c.beta)
                    res.bnd = BOUND_LOWER;
                else
                    res.bnd = BOUND_EXACT;
                tag_mirror[idx]  = c.hash;
                slot_mirror[idx] = res;
                res = '0;
            end
            default: begin
                tag_mirror.delete();
                slot_mirror.delete();
            end
        endcase
        return res;
    endfunction

    // entered and left at a falling edge; valid stays high across back-to-back items
    task automatic send_cmd(input tt_cmd_t c);
        int     gap;
        probe_t res;
        gap = src_burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {6'b0, c.mv, c.depth, c.bnd, c.beta, c.alpha, c.score, c.hash};
        do @(posedge aclk); while (!s_tready);
        res = tt_predict(c);
        if (c.op == OP_LOOKUP)
            pending_probes.push_back(c.typed ? c.want : res);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [HASH_W-1:0] h_a;
        logic [HASH_W-1:0] h_alias;
        tt_cmd_t           c;
        int                r;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        // hash zero, all ones, random tags, and tags sharing an index with others
        hash_pool[0] = '0;
        hash_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE / 2; k++)
            hash_pool[k] = {$urandom, $urandom};
        for (int k = POOL_SIZE / 2; k < POOL_SIZE; k++)
            hash_pool[k] = {32'($urandom), 16'($urandom),
                            hash_pool[k - POOL_SIZE / 2][INDEX_W-1:0]};

        h_a     = 64'h1234_5678_9abc_0005;
        h_alias = 64'hfedc_0000_0000_0005;
        directed_rows.push_back(probe_row('0, 1'b1, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(probe_row('1, 1'b0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_GIVEN, '1, -32768, 0, 0, BOUND_NONE,
                                        255, 65535));
        directed_rows.push_back(probe_row('1, 1'b1, -32768, BOUND_NONE, 255, 65535));
        // score on alpha, on beta, inside the window
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_a, 10, 10, 20, BOUND_NONE, 3, 'h0c1d));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_a, 20, 10, 20, BOUND_EXACT, 4, 'h0c1e));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_a, 15, 10, 20, BOUND_NONE, 5, 'h0c1f));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        // inverted window, both ways
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_a, 5, 30, 0, BOUND_NONE, 6, 'h8001));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_a, 40, 30, 0, BOUND_NONE, 7, 'h8002));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        // same index, other tag: miss, then replace
        directed_rows.push_back(probe_row(h_alias, 1'b0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_DERIVE, h_alias, 32767, -32768, 32767,
                                        BOUND_NONE, 8, 'hffff));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_alias, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_GIVEN, '0, 32767, 0, 0, BOUND_EXACT, 0, 0));
        directed_rows.push_back(cmd_row(OP_LOOKUP, '0, 0, 0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_CLEAR, h_a, -1, -1, -1, BOUND_EXACT, 255, 65535));
        directed_rows.push_back(probe_row('0, 1'b1, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(probe_row(h_alias, 1'b0, 0, BOUND_NONE, 0, 0));
        directed_rows.push_back(cmd_row(OP_SAVE_GIVEN, h_a, -1, 0, 0, BOUND_LOWER, 128, 'h5a5a));
        directed_rows.push_back(cmd_row(OP_LOOKUP, h_a, 0, 0, 0, BOUND_NONE, 0, 0));

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[n])
            send_cmd(directed_rows[n]);

        // mostly pool hashes so lookups hit; two clears spread over the run
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 50 == 0)
                src_burst = ($urandom_range(0, 3) == 0);
            r       = $urandom_range(0, 99);
            c.typed = 1'b0;
            c.want  = '0;
            if (i == RAND_ITEMS / 3 || i == 2 * RAND_ITEMS / 3)
                c.op = OP_CLEAR;
            else if (r < 50)
                c.op = OP_LOOKUP;
            else if (r < 75)
                c.op = OP_SAVE_DERIVE;
            else
                c.op = OP_SAVE_GIVEN;
            c.hash  = ($urandom_range(0, 99) < 85) ? hash_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : {$urandom, $urandom};
            c.alpha = 16'($urandom);
            c.beta  = ($urandom_range(0, 1) != 0) ? c.alpha + 16'($urandom_range(1, 40))
                                                  : 16'($urandom);
            case ($urandom_range(0, 5))
                0:       c.score = c.alpha;
                1:       c.score = c.beta;
                2:       c.score = c.alpha + 16'sd1;
                3:       c.score = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
                default: c.score = 16'($urandom);
            endcase
            c.bnd   = bound_t'($urandom_range(0, 3));
            c.depth = 8'($urandom);
            c.mv    = ($urandom_range(0, 15) == 0) ? '0 : 16'($urandom);
            send_cmd(c);
        end
        s_tvalid <= 1'b0;

        while (pending_probes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side back-pressure, redrawn per transfer
    initial begin : result_sink
        int stall;
        int taken;
        bit sink_burst;
        m_tready   = 1'b0;
        taken      = 0;
        sink_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            if (taken % 40 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            stall = sink_burst ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        probe_t got;
        probe_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit   = m_tuser;
            got.score = m_tdata[15:0];
            got.bnd   = bound_t'(m_tdata[17:16]);
            got.depth = m_tdata[25:18];
            got.mv    = m_tdata[41:26];
            if (pending_probes.size() == 0) begin
                flag_error($sformatf("lookup result with no lookup outstanding (hit %0b)",
                                     got.hit));
            end else begin
                want = pending_probes.pop_front();
                if (got.hit !== want.hit)
                    flag_error($sformatf("hit %0b, want %0b", got.hit, want.hit));
                if (got.score !== want.score)
                    flag_error($sformatf("score %0d, want %0d", got.score, want.score));
                if (got.bnd !== want.bnd)
                    flag_error($sformatf("bound %0d, want %0d", got.bnd, want.bnd));
                if (got.depth !== want.depth)
                    flag_error($sformatf("depth %0d, want %0d", got.depth, want.depth));
                if (got.mv !== want.mv)
                    flag_error($sformatf("move %h, want %h", got.mv, want.mv));
            end
        end
    end

    // ends a hung run: no transfer on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
